// ===== design/lprf_pkg.sv =====
// Shared types and codes for the length-prefixed record FIFO.
package lprf_pkg;

	localparam int RING_BYTES_DEF = 128;
	localparam int BYTE_W = 8;

	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_ROOM = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_SEQ     = 2'd3;

	typedef struct packed {
		logic [1:0]        action;
		logic [BYTE_W-1:0] record_len;
		logic [BYTE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [BYTE_W-1:0] data;
		logic [BYTE_W-1:0] stored_len;
		logic              last;
	} rsp_t;

endpackage

// ===== design/lprf_ram.sv =====
// Generic RAM, one write port and two registered read ports.
module lprf_ram
	import lprf_pkg::*;
#(
	parameter int WIDTH = BYTE_W,
	parameter int DEPTH = RING_BYTES_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== design/length_prefixed_record_fifo_top.sv =====
// Top level of the length-prefixed record FIFO.
// Latency: a word is held in stage s1 and its result is registered in rsp_q; a result
// stall holds both. Throughput: one word per cycle while rsp_stall is low; the ring RAM
// is read at the head length and the next payload address every cycle, with write bypass.
// Reset clears counts and flags and sets the pointers to their start (dp_q to 1); ring contents stay uninitialized.
module length_prefixed_record_fifo_top
	import lprf_pkg::*;
#(
	parameter int RING_BYTES = RING_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int PTR_W = $clog2(RING_BYTES);
	localparam int CNT_W = $clog2(RING_BYTES + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int CHK_W = BYTE_W + 2;

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(RING_BYTES - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	logic valid_s1;
	req_t req_s1;
	logic rsp_valid_q;
	rsp_t rsp_q;
	rsp_t rsp_d;
	logic fire;

	logic [PTR_W-1:0]  rp_q, rp_n, dp_q, dp_n, wp_q, wp_n;
	logic [CNT_W-1:0]  committed_q, committed_n, reserved_q, reserved_n;
	logic [BYTE_W-1:0] pending_q, pending_n, remain_q, remain_n, cur_len_q, cur_len_n;
	logic              open_q, open_n, reading_q, reading_n;

	logic              we;
	logic [BYTE_W-1:0] wdata;
	logic [BYTE_W-1:0] ram_a, ram_b;
	logic              fwd_a_q, fwd_b_q;
	logic [BYTE_W-1:0] fwd_data_q;
	logic [BYTE_W-1:0] len_a, byte_b;

	assign fire      = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !fire;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign len_a  = fwd_a_q ? fwd_data_q : ram_a;
	assign byte_b = fwd_b_q ? fwd_data_q : ram_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		if (fire) begin
			rsp_q <= rsp_d;
		end
		fwd_data_q <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q        <= '0;
			dp_q        <= PTR_W'(1);
			wp_q        <= '0;
			committed_q <= '0;
			reserved_q  <= '0;
			pending_q   <= '0;
			remain_q    <= '0;
			cur_len_q   <= '0;
			open_q      <= 1'b0;
			reading_q   <= 1'b0;
			fwd_a_q     <= 1'b0;
			fwd_b_q     <= 1'b0;
		end else begin
			rp_q        <= rp_n;
			dp_q        <= dp_n;
			wp_q        <= wp_n;
			committed_q <= committed_n;
			reserved_q  <= reserved_n;
			pending_q   <= pending_n;
			remain_q    <= remain_n;
			cur_len_q   <= cur_len_n;
			open_q      <= open_n;
			reading_q   <= reading_n;
			fwd_a_q     <= we && (wp_q == rp_n);
			fwd_b_q     <= we && (wp_q == dp_n);
		end
	end

	always_comb begin
		logic [BYTE_W-1:0] rlen;
		logic [BYTE_W-1:0] rem;
		logic [PTR_W-1:0]  dp_adv;
		logic [BYTE_W:0]   rlen_p1;
		logic              fits;
		rp_n        = rp_q;
		dp_n        = dp_q;
		wp_n        = wp_q;
		committed_n = committed_q;
		reserved_n  = reserved_q;
		pending_n   = pending_q;
		remain_n    = remain_q;
		cur_len_n   = cur_len_q;
		open_n      = open_q;
		reading_n   = reading_q;
		we          = 1'b0;
		wdata       = req_s1.value;
		rsp_d       = '0;
		rlen        = reading_q ? cur_len_q : len_a;
		rem         = reading_q ? remain_q : len_a;
		rlen_p1     = {1'b0, rlen} + 1'b1;
		dp_adv      = dp_q;
		fits        = (CHK_W'(committed_q) + CHK_W'(req_s1.record_len) + CHK_W'(1))
			<= CHK_W'(RING_BYTES);
		if (fire) begin
			unique case (req_s1.action)
				ACT_START: begin
					if (open_q) begin
						rsp_d.status = ST_SEQ;
					end else if (!fits) begin
						rsp_d.status = ST_NO_ROOM;
					end else begin
						we    = 1'b1;
						wdata = req_s1.record_len;
						wp_n  = wrap_inc(wp_q);
						if (req_s1.record_len == '0) begin
							committed_n = committed_q + 1'b1;
						end else begin
							open_n     = 1'b1;
							pending_n  = req_s1.record_len;
							reserved_n = CNT_W'({1'b0, req_s1.record_len} + 1'b1);
						end
					end
				end
				ACT_WRITE: begin
					if (!open_q) begin
						rsp_d.status = ST_SEQ;
					end else begin
						we        = 1'b1;
						wp_n      = wrap_inc(wp_q);
						pending_n = pending_q - 1'b1;
						if (pending_q == BYTE_W'(1)) begin
							committed_n = committed_q + reserved_q;
							reserved_n  = '0;
							open_n      = 1'b0;
						end
					end
				end
				ACT_READ: begin
					if (!reading_q && committed_q == '0) begin
						rsp_d.status = ST_EMPTY;
					end else begin
						rsp_d.stored_len = rlen;
						cur_len_n        = rlen;
						reading_n        = 1'b1;
						if (rem != '0) begin
							rsp_d.data = byte_b;
							remain_n   = rem - 1'b1;
							dp_adv     = wrap_inc(dp_q);
						end else begin
							remain_n = '0;
						end
						dp_n = dp_adv;
						if (rem <= BYTE_W'(1)) begin
							rsp_d.last = 1'b1;
							reading_n  = 1'b0;
							rp_n       = dp_adv;
							dp_n       = wrap_inc(dp_adv);
							if ((BYTE_W+1)'(committed_q) >= rlen_p1) begin
								committed_n = CNT_W'((BYTE_W+1)'(committed_q) - rlen_p1);
							end else begin
								committed_n = '0;
							end
						end
					end
				end
				default: begin
					rsp_d.status = ST_SEQ;
				end
			endcase
		end
	end

	lprf_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(RING_BYTES)
	) u_ring (
		.clk    (clk),
		.we     (we),
		.waddr  (wp_q),
		.wdata  (wdata),
		.raddr_a(rp_n),
		.rdata_a(ram_a),
		.raddr_b(dp_n),
		.rdata_b(ram_b)
	);

`ifndef SYNTHESIS
	a_space: assert property (@(posedge clk) disable iff (!arst_n)
		(SUM_W'(committed_q) + SUM_W'(reserved_q)) <= SUM_W'(RING_BYTES))
		else $error("committed plus reserved bytes exceed the ring");

	a_open_pending: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> (pending_q != '0))
		else $error("open record with no pending bytes");

	a_fire_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid)
		else $error("processed word produced no result");

	a_last_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.last) |-> (rsp.status == ST_OK && !reading_q))
		else $error("last mark on failed read or with read still open");
`endif

endmodule

// ===== tb/lprf_record_checker.sv =====
// Checker for the length-prefixed record FIFO: predicts each result word and compares it.
module lprf_record_checker
	import lprf_pkg::*;
#(
	parameter int RING_BYTES = RING_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   fail_count,
	output int   results_seen
);

	logic [7:0]  ring [RING_BYTES];
	int unsigned head_pos;
	int unsigned committed_bytes;
	int unsigned tail_pos;
	int unsigned bytes_owed;
	int unsigned reserved_bytes;
	int unsigned read_left;
	bit          rec_open;
	bit          rec_reading;

	rsp_t        due_rsp_q [$];
	int          mismatches;
	int          seen;

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < 40)
			$display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
		mismatches++;
	endtask

	// One step of the record ring: returns the result word for one request word.
	function automatic rsp_t predict_record_step(input req_t w);
		rsp_t        r;
		int unsigned rlen;
		int unsigned k;
		r = '0;
		r.status = ST_OK;
		case (w.action)
			ACT_START: begin
				if (rec_open) begin
					r.status = ST_SEQ;
				end else if (committed_bytes + w.record_len + 1 > RING_BYTES) begin
					r.status = ST_NO_ROOM;
				end else begin
					ring[tail_pos] = w.record_len;
					tail_pos = (tail_pos + 1) % RING_BYTES;
					if (w.record_len == 0) begin
						committed_bytes += 1;
					end else begin
						rec_open = 1'b1;
						bytes_owed = w.record_len;
						reserved_bytes = w.record_len + 1;
					end
				end
			end
			ACT_WRITE: begin
				if (!rec_open) begin
					r.status = ST_SEQ;
				end else begin
					ring[tail_pos] = w.value;
					tail_pos = (tail_pos + 1) % RING_BYTES;
					bytes_owed = (bytes_owed - 1) & 32'hFF;
					if (bytes_owed == 0) begin
						committed_bytes += reserved_bytes;
						reserved_bytes = 0;
						rec_open = 1'b0;
					end
				end
			end
			ACT_READ: begin
				if (!rec_reading && committed_bytes == 0) begin
					r.status = ST_EMPTY;
				end else begin
					rlen = ring[head_pos];
					if (!rec_reading) begin
						rec_reading = 1'b1;
						read_left = rlen;
					end
					r.stored_len = ring[head_pos];
					if (read_left != 0 && read_left <= rlen) begin
						k = rlen - read_left;
						r.data = ring[(head_pos + 1 + k) % RING_BYTES];
						read_left -= 1;
					end else begin
						read_left = 0;
					end
					if (read_left == 0) begin
						r.last = 1'b1;
						rec_reading = 1'b0;
						head_pos = (head_pos + rlen + 1) % RING_BYTES;
						committed_bytes = (committed_bytes >= rlen + 1) ?
							committed_bytes - (rlen + 1) : 0;
					end
				end
			end
			default: begin
				r.status = ST_SEQ;
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			head_pos = 0;
			committed_bytes = 0;
			tail_pos = 0;
			bytes_owed = 0;
			reserved_bytes = 0;
			read_left = 0;
			rec_open = 1'b0;
			rec_reading = 1'b0;
			due_rsp_q.delete();
			mismatches = 0;
			seen = 0;
			fail_count <= 0;
			results_seen <= 0;
		end else begin
			if (req_valid && !req_stall)
				due_rsp_q.push_back(predict_record_step(req));
			if (rsp_valid && !rsp_stall) begin
				seen++;
				if (due_rsp_q.size() == 0) begin
					report_mismatch("word with nothing expected", rsp, 0);
				end else begin
					want = due_rsp_q.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", rsp.status, want.status);
					if (rsp.data !== want.data)
						report_mismatch("data", rsp.data, want.data);
					if (rsp.stored_len !== want.stored_len)
						report_mismatch("stored_len", rsp.stored_len, want.stored_len);
					if (rsp.last !== want.last)
						report_mismatch("last", rsp.last, want.last);
				end
			end
			fail_count <= mismatches;
			results_seen <= seen;
		end
	end

endmodule

// ===== tb/tb_length_prefixed_record_fifo_top.sv =====
// Testbench top for the length-prefixed record FIFO: stimulus, backpressure and verdict.
module tb_length_prefixed_record_fifo_top;
	import lprf_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int   fail_count;
	int   results_seen;
	int   words_sent = 0;
	bit   quiet = 1'b0;
	int   stall_left = 0;

	length_prefixed_record_fifo_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	lprf_record_checker i_record_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp          (rsp),
		.fail_count   (fail_count),
		.results_seen (results_seen)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			rsp_stall <= 1'b1;
			stall_left <= $urandom_range(0, 15);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	task automatic send_word(input logic [1:0] act, input logic [7:0] len,
			input logic [7:0] val);
		int gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 16);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{action: act, record_len: len, value: val};
		@(posedge clk);
		while (req_stall) @(posedge clk);
		words_sent++;
	endtask

	task automatic read_burst(input int n);
		repeat (n) send_word(ACT_READ, 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
	endtask

	function automatic logic [7:0] pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 8'($urandom_range(0, 6));
		else if (r < 88)
			return 8'($urandom_range(7, 24));
		else
			return 8'($urandom_range(25, 127));
	endfunction

	initial begin
		int   pick;
		bit   draining;
		bit   paused;
		logic [7:0] len;
		draining = 1'b0;
		paused = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(ACT_READ, 8'h00, 8'h00);
		send_word(ACT_WRITE, 8'hFF, 8'hFF);
		send_word(ACT_UNUSED, 8'hFF, 8'hFF);
		send_word(ACT_START, 8'd0, 8'h00);
		send_word(ACT_READ, 8'h00, 8'h00);
		send_word(ACT_START, 8'd255, 8'h00);
		send_word(ACT_START, 8'd3, 8'h00);
		send_word(ACT_READ, 8'h00, 8'h00);
		send_word(ACT_START, 8'd5, 8'h00);
		send_word(ACT_WRITE, 8'h00, 8'h00);
		send_word(ACT_WRITE, 8'h00, 8'hFF);
		send_word(ACT_WRITE, 8'h00, 8'h5A);
		send_word(ACT_START, 8'd0, 8'h00);
		read_burst(5);
		send_word(ACT_START, 8'd254, 8'hA5);

		// fill the ring to the brim, then bounce off it
		send_word(ACT_START, 8'd127, 8'h00);
		repeat (127) send_word(ACT_WRITE, 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
		send_word(ACT_START, 8'd0, 8'h00);
		send_word(ACT_START, 8'd1, 8'h00);
		read_burst(128);

		while (words_sent < 750) begin
			if ($urandom_range(0, 7) == 0)
				draining = !draining;
			if (!paused && words_sent >= 420) begin
				paused = 1'b1;
				req_valid <= 1'b0;
				@(posedge clk);
				while (results_seen != words_sent) @(posedge clk);
			end
			if (words_sent >= 680)
				quiet <= 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				len = pick_len();
				send_word(ACT_START, len, 8'($urandom_range(0, 255)));
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, draining ? 2 : 9) == 0)
						send_word(ACT_READ, 8'($urandom_range(0, 255)),
							8'($urandom_range(0, 255)));
					send_word(ACT_WRITE, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
				end
			end else if (pick < 85) begin
				read_burst(draining ? $urandom_range(4, 40) : $urandom_range(1, 4));
			end else if (pick < 95) begin
				send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
			end else begin
				send_word(ACT_START, 8'($urandom_range(128, 255)),
					8'($urandom_range(0, 255)));
			end
		end
		req_valid <= 1'b0;

		@(posedge clk);
		while (results_seen != words_sent) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("[length_prefixed_record_fifo_top] OK");
		else
			$display("[length_prefixed_record_fifo_top] ERROR");
		$finish;
	end

	initial begin
		#10000000;
		$display("[length_prefixed_record_fifo_top] ERROR");
		$finish;
	end

endmodule
